/* rtl/core/gamma_contrast_brightness_correct_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gamma, contrast and brightness correction core.
// Simulation builds get concurrent assertions, synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef GAMMA_CONTRAST_BRIGHTNESS_CORRECT_CORE_DEFINES_SVH
`define GAMMA_CONTRAST_BRIGHTNESS_CORRECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define GCCC_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define GCCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define GCCC_ASSERT_ALWAYS(lbl, cond)
`define GCCC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/gccc_pkg.sv */
// ----------------------------------------------------------------------------
// gccc_pkg
// Shared types, constants and elaboration-time functions of the correction
// core.
// ----------------------------------------------------------------------------
package gccc_pkg;

   // Register indexes of the configuration port.
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_GAMMA      = 2'd0;
   localparam csr_index_type CSR_BRIGHTNESS = 2'd1;
   localparam csr_index_type CSR_CONTRAST   = 2'd2;

   // Legal register ranges.
   localparam int GAMMA_MIN  = 80;
   localparam int GAMMA_MAX  = 260;
   localparam int GAMMA_RST  = 100;
   localparam int OFFSET_MIN = -50;
   localparam int OFFSET_MAX = 50;

   // Percent scale, full scale and the exponent shift cut-off.
   localparam int PCT_SCALE    = 100;
   localparam int FULL_SCALE   = 255;
   localparam int HALF_PCT     = 50;
   localparam int SHIFT_LIMIT  = 40;

   // floor(s / 100) = (s * RECIP_100) >> RECIP_SHIFT for s below 43690.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   // Queue between front and back.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic full;
      logic empty;
   } gccc_fifo_stat_type;

   typedef struct packed {
      logic [8:0] gamma;
      logic [6:0] brightness;
      logic [6:0] contrast;
   } gccc_cfg_type;

   // Index of the top set bit, used to build the front tables.
   function automatic int msb_index(input int n);
      int k;
      k = 0;
      for (int b = 0; b < 31; b++) begin
         if (n[b]) begin
            k = b;
         end
      end
      return k;
   endfunction

   // Integer square root, used to build the exponent coefficients.
   function automatic longint unsigned isqrt64(input longint unsigned x);
      longint unsigned res;
      longint unsigned xr;
      longint unsigned bit_v;
      res   = 0;
      xr    = x;
      bit_v = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (xr >= res + bit_v) begin
            xr  = xr - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Coefficient 2^(-2^-i) in Q.32, built by repeated square roots of 0.5.
   function automatic logic [31:0] exp_coef(input int i);
      longint unsigned c;
      c = 64'h8000_0000;
      for (int j = 1; j <= i; j++) begin
         c = isqrt64(c << 32);
      end
      return c[31:0];
   endfunction

endpackage

/* rtl/core/gccc_fifo.sv */
// ----------------------------------------------------------------------------
// gccc_fifo
// Short queue between the front and the back of the correction core.
// ----------------------------------------------------------------------------
module gccc_fifo #(
   parameter int WIDTH = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output gccc_pkg::gccc_fifo_stat_type stat
);
   import gccc_pkg::*;

   logic [WIDTH-1:0]      mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage of the queued words.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

/* rtl/core/gccc_front.sv */
// ----------------------------------------------------------------------------
// gccc_front
// Accepts raw channel words, normalises them and splits the result into a
// mantissa and an exponent shift for the logarithm pipeline.
// ----------------------------------------------------------------------------
module gccc_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                                  req_tvalid,
   output logic                                                  req_tready,
   input  logic [7:0]                                            req_tdata,
   input  gccc_pkg::gccc_fifo_stat_type                          stat,
   output logic                                                  push,
   output logic [FRAC_BITS+1+$clog2(FRAC_BITS+1):0]              push_data
);
   import gccc_pkg::*;

   localparam int MW = FRAC_BITS + 1;
   localparam int SW = $clog2(FRAC_BITS + 1);

   logic [MW-1:0] mant_tab [256];
   logic [SW-1:0] sh_tab   [256];

   // Normalised value v/255 in Q.F, rounded half up, as mantissa and shift.
   for (genvar g = 0; g < 256; g++) begin : g_tab
      localparam longint NV = ((longint'(g) << (FRAC_BITS + 1)) + 255) / 510;
      localparam int     KV = (g == 0) ? FRAC_BITS : msb_index(int'(NV));
      assign mant_tab[g] = MW'(NV << (FRAC_BITS - KV));
      assign sh_tab[g]   = SW'(FRAC_BITS - KV);
   end

   // A word is taken whenever the queue has room.
   assign req_tready = !stat.full;
   assign push       = req_tvalid && req_tready;
   assign push_data  = {(req_tdata == 8'd0), sh_tab[req_tdata], mant_tab[req_tdata]};

endmodule

/* rtl/core/gccc_back.sv */
// ----------------------------------------------------------------------------
// gccc_back
// Pipelined gamma curve (log2, divide, exp2) followed by contrast, brightness,
// clamp and output scaling. The whole pipeline advances when the output
// register is free or being read.
// ----------------------------------------------------------------------------
module gccc_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  gccc_pkg::gccc_cfg_type                   cfg,
   input  logic                                     in_valid,
   input  logic [FRAC_BITS+1+$clog2(FRAC_BITS+1):0] in_data,
   output logic                                     in_take,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [7:0]                               rsp_tdata
);
   import gccc_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int MW   = F + 1;
   localparam int SW   = $clog2(F + 1);
   localparam int MAGW = SW + F;
   localparam int DVW  = MAGW + 7;
   localparam int QW   = DVW - F;
   localparam int AW   = F + 10;
   localparam int TW   = F + 7;
   localparam int PW   = F + 15;

   localparam logic signed [AW-1:0] HALF_V = AW'(1) << (F - 1);
   localparam logic signed [AW-1:0] MID_V  = AW'(PCT_SCALE) * HALF_V;
   localparam logic signed [AW-1:0] TOP_V  = AW'(PCT_SCALE) <<< F;
   localparam logic [PW-1:0]        RND_O  = PW'(HALF_PCT) << F;
   localparam logic [32:0]          ROUND_Y = 33'(1) << (31 - F);

   logic adv;

   assign adv     = !rsp_tvalid || rsp_tready;
   assign in_take = adv && in_valid;

   // ---------------------------------------------------------------- log2
   logic          lv_ff [F+1];
   logic          lz_ff [F+1];
   logic [MW-1:0] lm_ff [F+1];
   logic [F-1:0]  lf_ff [F+1];
   logic [SW-1:0] ls_ff [F+1];

   // First stage takes the queue head.
   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff[0] <= 1'b0;
      end else if (adv) begin
         lv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lm_ff[0] <= in_data[MW-1:0];
         ls_ff[0] <= in_data[MW+SW-1:MW];
         lz_ff[0] <= in_data[MW+SW];
         lf_ff[0] <= '0;
      end
   end

   // One fraction bit per stage by squaring the mantissa.
   for (genvar j = 0; j < F; j++) begin : g_log
      localparam logic [F-1:0] FBIT = F'(1) << (F - 1 - j);
      logic [2*MW-1:0] sq;
      logic [F+1:0]    sqs;

      assign sq  = (2*MW)'(lm_ff[j]) * (2*MW)'(lm_ff[j]);
      assign sqs = sq[2*F+1:F];

      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            lv_ff[j+1] <= lv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lz_ff[j+1] <= lz_ff[j];
            ls_ff[j+1] <= ls_ff[j];
            if (sqs[F+1]) begin
               lm_ff[j+1] <= sqs[F+1:1];
               lf_ff[j+1] <= lf_ff[j] | FBIT;
            end else begin
               lm_ff[j+1] <= sqs[F:0];
               lf_ff[j+1] <= lf_ff[j];
            end
         end
      end
   end

   // ------------------------------------------------------------- divide
   logic            dv_ff [DVW+1];
   logic            dz_ff [DVW+1];
   logic [8:0]      dr_ff [DVW+1];
   logic [DVW-1:0]  dw_ff [DVW+1];
   logic [MAGW-1:0] mag;

   // Magnitude of log2 times one hundred enters the divider.
   assign mag = {ls_ff[F], F'(0)} - MAGW'(lf_ff[F]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= lv_ff[F];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dz_ff[0] <= lz_ff[F];
         dr_ff[0] <= '0;
         dw_ff[0] <= DVW'(mag) * DVW'(PCT_SCALE);
      end
   end

   // Restoring division by the gamma register, one quotient bit per stage.
   for (genvar j = 0; j < DVW; j++) begin : g_div
      logic [9:0] r2;
      logic       ge;
      logic [9:0] rsub;

      assign r2   = {dr_ff[j], dw_ff[j][DVW-1]};
      assign ge   = (r2 >= {1'b0, cfg.gamma});
      assign rsub = r2 - {1'b0, cfg.gamma};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dz_ff[j+1] <= dz_ff[j];
            dr_ff[j+1] <= ge ? rsub[8:0] : r2[8:0];
            dw_ff[j+1] <= {dw_ff[j][DVW-2:0], ge};
         end
      end
   end

   // --------------------------------------------------------------- exp2
   logic          ev_ff [F+1];
   logic          ez_ff [F+1];
   logic          eo_ff [F+1];
   logic [31:0]   ey_ff [F+1];
   logic [QW-1:0] eq_ff [F+1];
   logic [F-1:0]  er_ff [F+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff[0] <= 1'b0;
      end else if (adv) begin
         ev_ff[0] <= dv_ff[DVW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ez_ff[0] <= dz_ff[DVW];
         eo_ff[0] <= 1'b1;
         ey_ff[0] <= '0;
         eq_ff[0] <= dw_ff[DVW][DVW-1:F];
         er_ff[0] <= dw_ff[DVW][F-1:0];
      end
   end

   // One coefficient multiply per fraction bit; a flag stands for exactly 1.0.
   for (genvar i = 1; i <= F; i++) begin : g_exp
      localparam logic [31:0] CI = exp_coef(i);
      logic [63:0] prod;

      assign prod = 64'(ey_ff[i-1]) * 64'(CI);

      always_ff @(posedge clock) begin
         if (reset) begin
            ev_ff[i] <= 1'b0;
         end else if (adv) begin
            ev_ff[i] <= ev_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ez_ff[i] <= ez_ff[i-1];
            eq_ff[i] <= eq_ff[i-1];
            er_ff[i] <= er_ff[i-1];
            if (er_ff[i-1][F-i]) begin
               eo_ff[i] <= 1'b0;
               ey_ff[i] <= eo_ff[i-1] ? CI : prod[63:32];
            end else begin
               eo_ff[i] <= eo_ff[i-1];
               ey_ff[i] <= ey_ff[i-1];
            end
         end
      end
   end

   // ------------------------------------------ integer shift and rounding
   logic          yv_ff;
   logic [F:0]    yf_ff;
   logic [32:0]   y33;
   logic [32:0]   ysh;
   logic [32:0]   yrn;

   assign y33 = eo_ff[F] ? 33'h1_0000_0000 : {1'b0, ey_ff[F]};
   assign ysh = (eq_ff[F] >= QW'(SHIFT_LIMIT)) ? '0 : (y33 >> eq_ff[F]);
   assign yrn = ysh + ROUND_Y;

   always_ff @(posedge clock) begin
      if (reset) begin
         yv_ff <= 1'b0;
      end else if (adv) begin
         yv_ff <= ev_ff[F];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yf_ff <= ez_ff[F] ? '0 : yrn[32:32-F];
      end
   end

   // ------------------------------------- contrast, brightness and clamp
   logic                 av_ff;
   logic [TW-1:0]        at_ff;
   logic signed [AW-1:0] yd;
   logic signed [AW-1:0] gain;
   logic signed [AW-1:0] tot;

   assign yd   = $signed({{(AW-F-1){1'b0}}, yf_ff}) - HALF_V;
   assign gain = AW'(PCT_SCALE) + AW'($signed(cfg.contrast));
   assign tot  = yd * gain + MID_V + (AW'($signed(cfg.brightness)) <<< F);

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= yv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         priority if (tot < 0) begin
            at_ff <= '0;
         end else if (tot > TOP_V) begin
            at_ff <= TW'(TOP_V);
         end else begin
            at_ff <= tot[TW-1:0];
         end
      end
   end

   // --------------------------------------------------- output scaling
   logic          sv_ff;
   logic [14:0]   s_ff;
   logic [PW-1:0] sfull;
   logic [27:0]   ofull;

   assign sfull = PW'(at_ff) * PW'(FULL_SCALE) + RND_O;
   assign ofull = 28'(s_ff) * 28'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else if (adv) begin
         sv_ff <= av_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= sfull[F+14:F];
      end
   end

   // Output register.
   logic       rv_ff;
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= sv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= ofull[RECIP_SHIFT+7:RECIP_SHIFT];
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

endmodule

/* rtl/core/gamma_contrast_brightness_correct_core.sv */
// ----------------------------------------------------------------------------
// gamma_contrast_brightness_correct_core
// Gamma, contrast and brightness correction of 8-bit colour channel words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw channel word per transfer, rsp_* returns one
//   corrected word per request word, in order. csr_* writes the gamma,
//   brightness and contrast registers; out-of-range values saturate and
//   index three is ignored. Write only while no word is in flight.
// Pipeline: an accepted word passes the front queue and then the back
//   pipeline before it reaches rsp_tvalid. The depth is set by
//   one pipeline stage per logarithm bit, per quotient bit of the divide by
//   gamma and per exponent coefficient.
// Throughput: one word per cycle, sustained while rsp_tready stays high.
// Stall: a low rsp_tready while rsp_tvalid is high freezes the whole back
//   pipeline; the front queue of four words keeps req_tready high until it fills.
// Reset: synchronous; the pipeline empties and the registers return to
//   gamma 1.00, brightness 0 and contrast 0.
// ----------------------------------------------------------------------------
`include "gamma_contrast_brightness_correct_core_defines.svh"

module gamma_contrast_brightness_correct_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] raw_value
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] corrected_value
   input  logic                    csr_wen,
   input  gccc_pkg::csr_index_type csr_addr,
   input  logic [8:0]              csr_wdata
);
   import gccc_pkg::*;

   localparam int EW = FRAC_BITS + 2 + $clog2(FRAC_BITS + 1);

   logic [8:0]         gamma_ff, gamma_in;
   logic signed [6:0]  bright_ff, bright_in;
   logic signed [6:0]  contrast_ff, contrast_in;
   logic signed [6:0]  wr_offset;
   logic signed [6:0]  sat_offset;
   gccc_cfg_type       cfg;
   gccc_fifo_stat_type stat;
   logic               push;
   logic               pop;
   logic [EW-1:0]      push_data;
   logic [EW-1:0]      pop_data;

   // Register writes with saturation to the legal ranges.
   assign wr_offset = $signed(csr_wdata[6:0]);

   always_comb begin
      priority if (wr_offset < 7'(OFFSET_MIN)) begin
         sat_offset = 7'(OFFSET_MIN);
      end else if (wr_offset > 7'(OFFSET_MAX)) begin
         sat_offset = 7'(OFFSET_MAX);
      end else begin
         sat_offset = wr_offset;
      end
   end

   always_comb begin
      gamma_in    = gamma_ff;
      bright_in   = bright_ff;
      contrast_in = contrast_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_GAMMA: begin
               priority if (csr_wdata < 9'(GAMMA_MIN)) begin
                  gamma_in = 9'(GAMMA_MIN);
               end else if (csr_wdata > 9'(GAMMA_MAX)) begin
                  gamma_in = 9'(GAMMA_MAX);
               end else begin
                  gamma_in = csr_wdata;
               end
            end
            CSR_BRIGHTNESS: begin
               bright_in = sat_offset;
            end
            CSR_CONTRAST: begin
               contrast_in = sat_offset;
            end
            default: begin
               gamma_in = gamma_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff    <= 9'(GAMMA_RST);
         bright_ff   <= '0;
         contrast_ff <= '0;
      end else begin
         gamma_ff    <= gamma_in;
         bright_ff   <= bright_in;
         contrast_ff <= contrast_in;
      end
   end

   assign cfg.gamma      = gamma_ff;
   assign cfg.brightness = bright_ff;
   assign cfg.contrast   = contrast_ff;

   // Front: accept and normalise.
   gccc_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .stat       (stat),
      .push       (push),
      .push_data  (push_data)
   );

   // Queue between the two halves.
   gccc_fifo #(
      .WIDTH (EW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (stat)
   );

   // Back: curve, adjustment and output register.
   gccc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (!stat.empty),
      .in_data    (pop_data),
      .in_take    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Checks on register ranges and holding.
   `GCCC_ASSERT_ALWAYS(a_gamma_range, (gamma_ff >= 9'(GAMMA_MIN)) && (gamma_ff <= 9'(GAMMA_MAX)))
   `GCCC_ASSERT_ALWAYS(a_bright_range, (bright_ff >= 7'(OFFSET_MIN)) && (bright_ff <= 7'(OFFSET_MAX)))
   `GCCC_ASSERT_ALWAYS(a_contr_range, (contrast_ff >= 7'(OFFSET_MIN)) && (contrast_ff <= 7'(OFFSET_MAX)))
   `GCCC_ASSERT_NEXT(a_cfg_hold, !csr_wen, $stable(gamma_ff) && $stable(contrast_ff))

endmodule
